FILE: rtl/ckl_pkg.sv
// Shared types and codes for the compacting key list.
// No dependencies; every other file in rtl/ but ckl_ram imports this package.
package ckl_pkg;

   localparam int CMD_BITS       = 2;
   localparam int KEY_FIELD_BITS = 16;
   localparam int POS_BITS       = 6;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_BITS     = 7;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ERASE  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD_POS   = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]       command;
      logic [KEY_FIELD_BITS-1:0] key;
      logic [POS_BITS-1:0]       position;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [POS_BITS-1:0]    found_position;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ERASE,
      S_FIND,
      S_DONE
   } state_type;

endpackage

FILE: rtl/ckl_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ckl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ckl_ctrl.sv
// Command sequencer: entry count, erase shift walk and find scan over the key RAM.
// Depends on ckl_pkg.
module ckl_ctrl #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ckl_pkg::req_type            req_payload,
   output logic                        res_valid,
   input  logic                        res_ready,
   output ckl_pkg::rsp_type            res,
   output logic                        ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
   output logic [KEY_BITS-1:0]         ram_wr_data,
   output logic                        ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
   input  logic [KEY_BITS-1:0]         ram_rd_data
);

   import ckl_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_idx_ff, pend_idx_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic [POS_BITS-1:0]      found_ff, found_in;

   logic issue_rd;
   logic walk_done;
   logic match;
   logic pos_bad;
   logic full;

   assign issue_rd  = (rd_idx_ff < count_ff);
   assign walk_done = !issue_rd && !pend_ff;
   assign match     = pend_ff && (ram_rd_data == key_ff);
   assign pos_bad   = (CMPW'(req_payload.position) >= CMPW'(count_ff));
   assign full      = (count_ff == CW'(CAPACITY));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.command)
                  CMD_ERASE: state_in = pos_bad ? S_DONE : S_ERASE;
                  CMD_FIND:  state_in = S_FIND;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_ERASE: begin
            if (walk_done) state_in = S_DONE;
         end
         S_FIND: begin
            if (match || walk_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = key_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[AW-1:0];
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               found_in  = '0;
               rd_idx_in = '0;
               key_in    = KEY_BITS'(req_payload.key);
               unique case (req_payload.command)
                  CMD_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = KEY_BITS'(req_payload.key);
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  CMD_ERASE: begin
                     if (pos_bad) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        rd_idx_in = CW'(CMPW'(req_payload.position) + CMPW'(1));
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ERASE: begin
            // read entry i, write it to i-1 on the next cycle
            ram_rd_en   = issue_rd;
            pend_in     = issue_rd;
            pend_idx_in = rd_idx_ff[AW-1:0];
            if (issue_rd) rd_idx_in = rd_idx_ff + CW'(1);
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_idx_ff - AW'(1);
               ram_wr_data = ram_rd_data;
            end
            if (walk_done) count_in = count_ff - CW'(1);
         end
         S_FIND: begin
            ram_rd_en   = issue_rd;
            pend_in     = issue_rd;
            pend_idx_in = rd_idx_ff[AW-1:0];
            if (issue_rd) rd_idx_in = rd_idx_ff + CW'(1);
            if (match) begin
               found_in = POS_BITS'(pend_idx_ff);
            end else if (walk_done) begin
               status_in = ST_NOT_FOUND;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign res.status         = status_ff;
   assign res.found_position = found_ff;
   assign res.entry_count    = COUNT_BITS'(count_ff);

endmodule

FILE: rtl/ckl_rsp_reg.sv
// Result output register; frees the sequencer while a result waits downstream.
// Depends on ckl_pkg.
module ckl_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   output logic             res_ready,
   input  ckl_pkg::rsp_type res,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ckl_pkg::rsp_type rsp_payload
);

   import ckl_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    load;

   assign res_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/compacting_key_list.sv
// Compacting key list: an ordered list of up to CAPACITY keys held in one RAM, taking one
// command at a time. Append, an erase with a bad position and an unused command code go
// from idle straight to the result state. Erase walks the single RAM read port over the
// entries behind the erased one and writes each one slot lower, one entry per cycle.
// Find scans from position 0, one RAM read per cycle, and stops on the first hit or,
// on a miss, after the last entry (at once on an empty list). The result sits in an
// output register, so the next command can start while a result is still stalled.
module compacting_key_list #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ckl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ckl_pkg::rsp_type rsp_payload
);

   import ckl_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                res_valid;
   logic                res_ready;
   rsp_type             res;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [KEY_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [KEY_BITS-1:0] ram_rd_data;

   ckl_ctrl #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ckl_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ckl_rsp_reg u_rsp (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/ckl_checker.sv
// Port-level checks for compacting_key_list, attached by the bind below.
// Depends on ckl_pkg.
module ckl_checker #(
   parameter int CAPACITY = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ckl_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ckl_pkg::rsp_type rsp_payload
);

   import ckl_pkg::*;

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // one command in flight: an accepted request blocks the next cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_FULL)
      |-> rsp_payload.entry_count == COUNT_BITS'(CAPACITY))
      else $error("full status with list not full");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |-> rsp_payload.found_position == '0)
      else $error("position reported on failed command");

   // an accepted request always carries a known command
   a_req_used: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !$isunknown(req_payload.command))
      else $error("unknown command accepted");

endmodule

bind compacting_key_list ckl_checker #(
   .CAPACITY (CAPACITY)
) u_ckl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
